>>> sv/byte_pipe_ring_buffer_top_assert.svh
// Assertion macros for the byte pipe ring buffer.
// Each macro assumes a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef BYTE_PIPE_RING_BUFFER_TOP_ASSERT_SVH
`define BYTE_PIPE_RING_BUFFER_TOP_ASSERT_SVH

// Invariant checked on every clock edge outside reset.
`define BPRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked in the same cycle.
`define BPRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/bprb_pkg.sv
// Shared widths, codes and types of the byte pipe ring buffer.
// No dependencies.
`default_nettype none

package bprb_pkg;

    localparam int CNT_W     = 13;
    localparam int MODE_W    = 2;
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATOMIC   = 2'd1;

    localparam int RST_CAPACITY = 4096;
    localparam int RST_ATOMIC   = 512;

    // One result slot issued by the controller; is_mem means the data byte
    // comes from the store read port in the cycle after the issue.
    typedef struct packed {
        logic              valid;
        logic              is_mem;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  granted;
        logic              last;
    } t_issue;

endpackage

`default_nettype wire

>>> sv/byte_pipe_ring_buffer_top.sv
// Byte pipe ring buffer top level: controller, byte store and result queue.
// Depends on bprb_pkg, bprb_store, bprb_ctrl and the assertion macro header.
//
// Input channel (i_in_valid / o_in_ready) carries one item per transaction:
// a write byte, a read request or an end-of-stream mark. Result channel
// (o_out_valid / i_out_ready) returns kind, data byte, granted count, last.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes register
// 0 (capacity, empties the pipe) or 1 (atomic limit); other indexes drop.
// Writes, end marks and refused or empty reads leave the controller idle,
// so the next item may follow once there is result credit. A read request
// of n bytes holds the input until min(n, bytes stored, MAX_READ_BURST)
// bytes are issued, one store read-port access per byte, one byte per
// cycle while result credit lasts.
// Results pass a read pipeline stage into a two-entry queue; a credit
// count stalls new issues when the receiver stops taking results, and
// nothing is lost. Reset (i_rst_n, synchronous) empties the pipe, opens it
// and loads capacity 4096 and atomic limit 512; store contents are not
// cleared and never read before written.
`default_nettype none

`include "byte_pipe_ring_buffer_top_assert.svh"

module byte_pipe_ring_buffer_top
    import bprb_pkg::*;
#(
    parameter int STORE_DEPTH    = 4096,
    parameter int MAX_READ_BURST = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [BYTE_W-1:0]    i_data_byte,
    input  wire logic [CNT_W-1:0]     i_request_count,
    input  wire logic                 i_first,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [KIND_W-1:0]    o_kind,
    output logic      [BYTE_W-1:0]    o_data_byte_out,
    output logic      [CNT_W-1:0]     o_granted_count,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = (AW > CNT_W) ? AW : CNT_W;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  granted;
        logic              last;
    } t_result;

    t_issue            issue;
    logic              issue_ok;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    t_issue            r_pend;
    t_result           r_fifo [2];
    logic              r_wr_idx;
    logic              r_rd_idx;
    logic [1:0]        r_occ;
    logic              pop;
    logic [2:0]        fill;
    t_result           head;

    assign o_cfg_ready = 1'b1;

    bprb_ctrl #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_READ_BURST (MAX_READ_BURST),
        .AW             (AW),
        .PW             (PW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_data_byte     (i_data_byte),
        .i_request_count (i_request_count),
        .i_first         (i_first),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_issue_ok      (issue_ok),
        .o_issue         (issue),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr)
    );

    bprb_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign pop  = o_out_valid && i_out_ready;
    // Slots still claimed after this cycle; one more issue fits below two.
    assign fill = 3'(r_occ) + 3'(r_pend.valid) - 3'(pop);
    assign issue_ok = (fill < 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend.valid <= 1'b0;
        end else begin
            r_pend.valid <= issue.valid;
        end
        r_pend.is_mem  <= issue.is_mem;
        r_pend.kind    <= issue.kind;
        r_pend.granted <= issue.granted;
        r_pend.last    <= issue.last;
    end

    always_ff @(posedge i_clk) begin
        if (r_pend.valid) begin
            r_fifo[r_wr_idx].kind    <= r_pend.kind;
            r_fifo[r_wr_idx].data    <= r_pend.is_mem ? mem_rdata : '0;
            r_fifo[r_wr_idx].granted <= r_pend.granted;
            r_fifo[r_wr_idx].last    <= r_pend.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_occ    <= '0;
        end else begin
            if (r_pend.valid) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            r_occ <= 2'(fill);
        end
    end

    assign head            = r_fifo[r_rd_idx];
    assign o_out_valid     = (r_occ != '0);
    assign o_kind          = head.kind;
    assign o_data_byte_out = head.data;
    assign o_granted_count = head.granted;
    assign o_last          = head.last;

    `BPRB_ASSERT(a_occ_bound, r_occ <= 2'd2, "result queue over two entries")
    `BPRB_ASSERT_IMP(a_push_room, r_pend.valid, (r_occ < 2'd2) || pop, "push into full queue")
    `BPRB_ASSERT_IMP(a_issue_credit, issue.valid, issue_ok, "result issued without credit")

endmodule

`default_nettype wire

>>> sv/bprb_store.sv
// Byte store: one write port, one read port, registered read data.
// Depends on bprb_pkg for the byte width.
`default_nettype none

module bprb_store
    import bprb_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/bprb_ctrl.sv
// Pointer, burst and read sequencing control of the byte pipe.
// Depends on bprb_pkg and the assertion macro header.
`default_nettype none

`include "byte_pipe_ring_buffer_top_assert.svh"

module bprb_ctrl
    import bprb_pkg::*;
#(
    parameter int STORE_DEPTH    = 4096,
    parameter int MAX_READ_BURST = 64,
    parameter int AW             = 12,
    parameter int PW             = 13
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [BYTE_W-1:0]    i_data_byte,
    input  wire logic [CNT_W-1:0]     i_request_count,
    input  wire logic                 i_first,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    input  wire logic                 i_issue_ok,
    output t_issue                    o_issue,
    output logic                      o_mem_we,
    output logic      [AW-1:0]        o_mem_waddr,
    output logic      [BYTE_W-1:0]    o_mem_wdata,
    output logic                      o_mem_re,
    output logic      [AW-1:0]        o_mem_raddr
);

    localparam int RBW = $clog2(MAX_READ_BURST + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    function automatic logic [PW-1:0] sat_cap(input logic [CNT_W-1:0] v);
        logic [PW:0] vx;
        logic [PW:0] lim;
        vx  = (PW+1)'(v);
        lim = (PW+1)'(STORE_DEPTH);
        if (v == '0) begin
            sat_cap = PW'(1);
        end else if (vx > lim) begin
            sat_cap = PW'(STORE_DEPTH);
        end else begin
            sat_cap = PW'(v);
        end
    endfunction

    logic             r_state,   n_state;
    logic [PW-1:0]    r_wp,      n_wp;
    logic [PW-1:0]    r_rp,      n_rp;
    logic             r_wrap,    n_wrap;
    logic             r_closed,  n_closed;
    logic [CNT_W-1:0] r_left,    n_left;
    logic             r_discard, n_discard;
    logic [PW-1:0]    r_cap,     n_cap;
    logic [CNT_W-1:0] r_atomic,  n_atomic;
    logic [RBW-1:0]   r_rd_left, n_rd_left;

    logic [PW:0]    used_x;
    logic [PW-1:0]  used;
    logic [PW-1:0]  free_b;
    logic [PW-1:0]  cnt_x;
    logic [PW-1:0]  grant_x;
    logic           refuse;
    logic [PW-1:0]  rd_m1;
    logic [PW-1:0]  rd_n;
    logic [PW-1:0]  wp_inc;
    logic [PW-1:0]  rp_inc;
    logic           accept;

    // Fill level from the pointers; the wrap flag tells full from empty.
    always_comb begin
        if (!r_wrap) begin
            used_x = (r_wp >= r_rp) ? (PW+1)'(r_wp - r_rp) : '0;
        end else if (r_rp <= r_cap) begin
            used_x = (PW+1)'(r_cap - r_rp) + (PW+1)'(r_wp);
        end else begin
            used_x = (PW+1)'(r_wp);
        end
        used = (used_x > (PW+1)'(r_cap)) ? r_cap : PW'(used_x);
    end

    assign free_b  = r_cap - used;
    assign cnt_x   = PW'(i_request_count);
    assign grant_x = (i_request_count > r_atomic) ? ((free_b < cnt_x) ? free_b : cnt_x)
                                                  : cnt_x;
    assign refuse  = (free_b == '0) || (grant_x > free_b);
    assign rd_m1   = (used < cnt_x) ? used : cnt_x;
    assign rd_n    = (rd_m1 < PW'(MAX_READ_BURST)) ? rd_m1 : PW'(MAX_READ_BURST);
    assign wp_inc  = r_wp + PW'(1);
    assign rp_inc  = r_rp + PW'(1);

    assign o_in_ready = (r_state == ST_IDLE) && i_issue_ok;
    assign accept     = i_in_valid && o_in_ready;

    assign o_mem_waddr = r_wp[AW-1:0];
    assign o_mem_wdata = i_data_byte;
    assign o_mem_raddr = r_rp[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_wrap    = r_wrap;
        n_closed  = r_closed;
        n_left    = r_left;
        n_discard = r_discard;
        n_cap     = r_cap;
        n_atomic  = r_atomic;
        n_rd_left = r_rd_left;
        o_issue   = '0;
        o_mem_we  = 1'b0;
        o_mem_re  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_WRITE: begin
                            if (!i_first) begin
                                if (!r_discard && (r_left != '0)) begin
                                    o_mem_we = 1'b1;
                                    n_left   = r_left - CNT_W'(1);
                                end
                            end else if (r_closed) begin
                                n_left        = '0;
                                n_discard     = 1'b1;
                                o_issue.valid = 1'b1;
                                o_issue.kind  = KIND_CLOSED;
                                o_issue.last  = 1'b1;
                            end else if (refuse) begin
                                n_left        = '0;
                                n_discard     = 1'b1;
                                o_issue.valid = 1'b1;
                                o_issue.kind  = KIND_BLOCK;
                                o_issue.last  = 1'b1;
                            end else begin
                                n_discard       = 1'b0;
                                n_left          = '0;
                                if (grant_x != '0) begin
                                    o_mem_we = 1'b1;
                                    n_left   = CNT_W'(grant_x - PW'(1));
                                end
                                o_issue.valid   = 1'b1;
                                o_issue.kind    = KIND_GRANT;
                                o_issue.granted = CNT_W'(grant_x);
                                o_issue.last    = 1'b1;
                            end
                        end
                        MODE_READ: begin
                            if (used == '0) begin
                                o_issue.valid = 1'b1;
                                o_issue.kind  = r_closed ? KIND_CLOSED : KIND_BLOCK;
                                o_issue.last  = 1'b1;
                            end else if (rd_n != '0) begin
                                n_state   = ST_READ;
                                n_rd_left = RBW'(rd_n);
                            end
                        end
                        MODE_END: begin
                            n_closed = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (i_issue_ok) begin
                    o_mem_re       = 1'b1;
                    o_issue.valid  = 1'b1;
                    o_issue.is_mem = 1'b1;
                    o_issue.kind   = KIND_DATA;
                    o_issue.last   = (r_rd_left == RBW'(1));
                    n_rd_left      = r_rd_left - RBW'(1);
                    if (r_rd_left == RBW'(1)) begin
                        n_state = ST_IDLE;
                    end
                    if (rp_inc >= r_cap) begin
                        n_rp   = '0;
                        n_wrap = 1'b0;
                    end else begin
                        n_rp = rp_inc;
                    end
                end
            end
        endcase

        if (o_mem_we) begin
            if (wp_inc >= r_cap) begin
                n_wp   = '0;
                n_wrap = 1'b1;
            end else begin
                n_wp = wp_inc;
            end
        end

        // Capacity change empties the pipe; the closed flag survives.
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                n_cap     = sat_cap(i_cfg_data);
                n_wp      = '0;
                n_rp      = '0;
                n_wrap    = 1'b0;
                n_left    = '0;
                n_discard = 1'b0;
            end else if (i_cfg_index == CFG_ATOMIC) begin
                n_atomic = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_wrap    <= 1'b0;
            r_closed  <= 1'b0;
            r_left    <= '0;
            r_discard <= 1'b0;
            r_cap     <= sat_cap(CNT_W'(RST_CAPACITY));
            r_atomic  <= CNT_W'(RST_ATOMIC);
            r_rd_left <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_wrap    <= n_wrap;
            r_closed  <= n_closed;
            r_left    <= n_left;
            r_discard <= n_discard;
            r_cap     <= n_cap;
            r_atomic  <= n_atomic;
            r_rd_left <= n_rd_left;
        end
    end

    `BPRB_ASSERT(a_ptr_in_range, (r_wp < r_cap) && (r_rp < r_cap), "pointer beyond capacity")
    `BPRB_ASSERT(a_wrap_order, r_wrap ? (r_wp <= r_rp) : (r_wp >= r_rp), "wrap flag inconsistent")
    `BPRB_ASSERT_IMP(a_no_write_full, o_mem_we, used < r_cap, "byte stored into full store")
    `BPRB_ASSERT_IMP(a_no_read_empty, o_mem_re, used != '0, "byte read from empty store")

endmodule

`default_nettype wire

>>> verif/tb_byte_pipe_ring_buffer_top.sv
// Self-checking testbench for byte_pipe_ring_buffer_top: directed script, random
// write bursts and read requests over several capacity and atomic-limit settings, then the rest of the script.
// Depends on bprb_pkg and the byte_pipe_ring_buffer_top RTL.
`default_nettype none

module tb_byte_pipe_ring_buffer_top;
    import bprb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH      = 4096;
    localparam int MEM_AW           = $clog2(STORE_DEPTH);
    localparam int READ_BURST_MAX   = 64;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int NUM_PHASES       = 5;

    localparam logic [MODE_W-1:0]    MODE_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [1:0] ROW_ITEM  = 2'd0;
    localparam logic [1:0] ROW_CFG   = 2'd1;
    localparam logic [1:0] ROW_BREAK = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  granted;
        logic              last;
    } t_pipe_result;

    // sel holds the mode of an item row or the register index of a config row;
    // cnt holds the request count or the register value.
    typedef struct packed {
        logic [1:0]        row_kind;
        logic [1:0]        sel;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
        logic              first;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  granted;
    } t_dir_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [MODE_W-1:0]    in_mode = MODE_IGNORED;
    logic [BYTE_W-1:0]    in_data = '0;
    logic [CNT_W-1:0]     in_count = '0;
    logic                 in_first = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [KIND_W-1:0]    out_kind;
    logic [BYTE_W-1:0]    out_data;
    logic [CNT_W-1:0]     out_granted;
    logic                 out_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int items_done = 0;

    t_pipe_result pending_results [$];
    t_pipe_result head_res;

    // predictor state
    logic [BYTE_W-1:0] pipe_mem [STORE_DEPTH];
    logic [CNT_W-1:0]  wr_ptr = '0;
    logic [CNT_W-1:0]  rd_ptr = '0;
    logic              wrap_set = 1'b0;
    logic              pipe_closed = 1'b0;
    logic [CNT_W-1:0]  burst_left = '0;
    logic              burst_dropping = 1'b0;
    logic [CNT_W-1:0]  cfg_capacity = CNT_W'(RST_CAPACITY);
    logic [CNT_W-1:0]  cfg_atomic = CNT_W'(RST_ATOMIC);

    t_pipe_result step_res [READ_BURST_MAX];
    int           step_cnt;

    int phase_cap    [NUM_PHASES] = '{0, 16, 8191, 40, 4096};
    int phase_atomic [NUM_PHASES] = '{0, 8, 4096, 40, 8191};

    t_dir_row script [$] = '{
        // after reset: capacity 4096, atomic limit 512
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd5,    1'b0, 1'b1, KIND_BLOCK, 13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h00, 13'd0,    1'b1, 1'b1, KIND_GRANT, 13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'hFF, 13'd8191, 1'b1, 1'b1, KIND_GRANT, 13'd4096},
        '{ROW_ITEM, MODE_WRITE, 8'h00, 13'd2,    1'b1, 1'b1, KIND_GRANT, 13'd2},
        '{ROW_ITEM, MODE_WRITE, 8'hAA, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h55, 13'd8191, 1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'hFF, 13'd8191, 1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd1,    1'b0, 1'b1, KIND_BLOCK, 13'd0},
        '{ROW_ITEM, MODE_IGNORED, 8'hFF, 13'd8191, 1'b1, 1'b0, KIND_DATA, 13'd0},
        '{ROW_CFG,  CFG_CAPACITY, 8'h00, 13'd4,  1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_CFG,  CFG_ATOMIC,   8'h00, 13'd3,  1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h01, 13'd3,    1'b1, 1'b1, KIND_GRANT, 13'd3},
        '{ROW_ITEM, MODE_WRITE, 8'h02, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h03, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        // atomic burst that does not fit, then its tail is thrown away
        '{ROW_ITEM, MODE_WRITE, 8'h04, 13'd2,    1'b1, 1'b1, KIND_BLOCK, 13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h05, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h06, 13'd9,    1'b1, 1'b1, KIND_GRANT, 13'd1},
        '{ROW_ITEM, MODE_WRITE, 8'h07, 13'd1,    1'b1, 1'b1, KIND_BLOCK, 13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd64,   1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h08, 13'd3,    1'b1, 1'b1, KIND_GRANT, 13'd3},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd2,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_BREAK, 2'd0,      8'h00, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        // end of stream: granted bytes still land, new bursts and empty reads close
        '{ROW_CFG,  CFG_CAPACITY, 8'h00, 13'd8,  1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_CFG,  CFG_ATOMIC,   8'h00, 13'd8,  1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h10, 13'd3,    1'b1, 1'b1, KIND_GRANT, 13'd3},
        '{ROW_ITEM, MODE_END,   8'h00, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h11, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h12, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd64,   1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd0,    1'b0, 1'b1, KIND_CLOSED, 13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h13, 13'd1,    1'b1, 1'b1, KIND_CLOSED, 13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'h14, 13'd0,    1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd1,    1'b0, 1'b1, KIND_CLOSED, 13'd0},
        '{ROW_CFG,  CFG_CAPACITY, 8'h00, 13'd2,  1'b0, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_READ,  8'h00, 13'd5,    1'b0, 1'b1, KIND_CLOSED, 13'd0},
        '{ROW_ITEM, MODE_END,   8'hFF, 13'd8191, 1'b1, 1'b0, KIND_DATA,  13'd0},
        '{ROW_ITEM, MODE_WRITE, 8'hFF, 13'd0,    1'b1, 1'b1, KIND_CLOSED, 13'd0}
    };

    byte_pipe_ring_buffer_top #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_READ_BURST (READ_BURST_MAX)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_data_byte     (in_data),
        .i_request_count (in_count),
        .i_first         (in_first),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (out_kind),
        .o_data_byte_out (out_data),
        .o_granted_count (out_granted),
        .o_last          (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [CNT_W-1:0] eff_capacity();
        if (cfg_capacity == '0)
            return CNT_W'(1);
        if (cfg_capacity > CNT_W'(STORE_DEPTH))
            return CNT_W'(STORE_DEPTH);
        return cfg_capacity;
    endfunction

    function automatic logic [CNT_W-1:0] bytes_held();
        logic [CNT_W-1:0] cap;
        logic [CNT_W:0]   held;
        cap = eff_capacity();
        if (!wrap_set)
            held = (wr_ptr >= rd_ptr) ? {1'b0, wr_ptr - rd_ptr} : '0;
        else if (rd_ptr <= cap)
            held = {1'b0, cap} - {1'b0, rd_ptr} + {1'b0, wr_ptr};
        else
            held = {1'b0, wr_ptr};
        return (held > {1'b0, cap}) ? cap : held[CNT_W-1:0];
    endfunction

    function automatic void add_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                       logic [CNT_W-1:0] granted, logic last);
        step_res[step_cnt] = '{kind, data, granted, last};
        step_cnt++;
    endfunction

    function automatic void push_byte(logic [BYTE_W-1:0] b);
        pipe_mem[wr_ptr[MEM_AW-1:0]] = b;
        wr_ptr++;
        if (wr_ptr >= eff_capacity()) begin
            wr_ptr   = '0;
            wrap_set = 1'b1;
        end
    endfunction

    function automatic void empty_pipe();
        wr_ptr         = '0;
        rd_ptr         = '0;
        wrap_set       = 1'b0;
        burst_left     = '0;
        burst_dropping = 1'b0;
    endfunction

    function automatic void predict_config(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        if (idx == CFG_CAPACITY) begin
            cfg_capacity = val;
            empty_pipe();
        end else if (idx == CFG_ATOMIC) begin
            cfg_atomic = val;
        end
    endfunction

    function automatic void predict_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                                         logic [CNT_W-1:0] cnt, logic first);
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] room;
        logic [CNT_W-1:0] grant;
        logic [CNT_W-1:0] n;
        step_cnt    = 0;
        cap         = eff_capacity();
        case (mode)
            MODE_WRITE: begin
                if (!first) begin
                    if (!burst_dropping && burst_left > 0) begin
                        push_byte(data);
                        burst_left--;
                    end
                end else if (pipe_closed) begin
                    burst_left     = '0;
                    burst_dropping = 1'b1;
                    add_result(KIND_CLOSED, '0, '0, 1'b1);
                end else begin
                    room  = cap - bytes_held();
                    grant = cnt;
                    if (cnt > cfg_atomic && room < cnt)
                        grant = room;
                    if (room == '0 || grant > room) begin
                        burst_left     = '0;
                        burst_dropping = 1'b1;
                        add_result(KIND_BLOCK, '0, '0, 1'b1);
                    end else begin
                        burst_dropping = 1'b0;
                        burst_left     = '0;
                        if (grant > 0) begin
                            push_byte(data);
                            burst_left = grant - 1'b1;
                        end
                        add_result(KIND_GRANT, '0, grant, 1'b1);
                    end
                end
            end
            MODE_READ: begin
                n = bytes_held();
                if (n == '0) begin
                    add_result(pipe_closed ? KIND_CLOSED : KIND_BLOCK, '0, '0, 1'b1);
                end else begin
                    if (cnt < n)
                        n = cnt;
                    if (n > CNT_W'(READ_BURST_MAX))
                        n = CNT_W'(READ_BURST_MAX);
                    for (int k = 0; k < int'(n); k++) begin
                        add_result(KIND_DATA, pipe_mem[rd_ptr[MEM_AW-1:0]], '0,
                                   k + 1 == int'(n));
                        rd_ptr++;
                        if (rd_ptr >= cap) begin
                            rd_ptr   = '0;
                            wrap_set = 1'b0;
                        end
                    end
                end
            end
            MODE_END: pipe_closed = 1'b1;
            default: begin
            end
        endcase
    endfunction

    // ---------------- drivers ----------------

    function automatic t_dir_row item_row(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                                          logic [CNT_W-1:0] cnt, logic first);
        return '{ROW_ITEM, mode, data, cnt, first, 1'b0, KIND_DATA, '0};
    endfunction

    task automatic send_row(t_dir_row r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= r.sel;
        in_data  <= r.data;
        in_count <= r.cnt;
        in_first <= r.first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(r.sel, r.data, r.cnt, r.first);
        if (r.typed)
            pending_results.push_back('{r.kind, '0, r.granted, 1'b1});
        else
            for (int k = 0; k < step_cnt; k++)
                pending_results.push_back(step_res[k]);
        items_done++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // follow-on bytes and end marks give no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predict_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic walk_script(inout int pos);
        while (pos < script.size() && script[pos].row_kind != ROW_BREAK) begin
            if (script[pos].row_kind == ROW_CFG)
                write_reg(script[pos].sel, script[pos].cnt);
            else
                send_row(script[pos]);
            pos++;
        end
        pos++;
    endtask

    task automatic random_phase(int n_items);
        int unsigned pick;
        int unsigned len;
        int unsigned tail;
        int unsigned cnt;
        items_done = 0;
        while (items_done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // a well-formed burst most of the time, sometimes cut short or overrun
                pick = $urandom_range(99);
                if (pick < 8)
                    len = 0;
                else if (pick < 70)
                    len = $urandom_range(12, 1);
                else if (pick < 85)
                    len = $urandom_range(40, 13);
                else if (pick < 95)
                    len = (cfg_atomic + $urandom_range(1)) & 13'h1FFF;
                else
                    len = $urandom_range(8191);
                send_row(item_row(MODE_WRITE, BYTE_W'($urandom_range(255)), CNT_W'(len),
                                  1'b1));
                tail = (len == 0) ? 0 : len - 1;
                if (tail > 40)
                    tail = $urandom_range(40);
                pick = $urandom_range(9);
                if (pick == 0)
                    tail = $urandom_range(tail);
                else if (pick == 1)
                    tail = tail + $urandom_range(3, 1);
                repeat (tail)
                    send_row(item_row(MODE_WRITE, BYTE_W'($urandom_range(255)),
                                      CNT_W'($urandom_range(8191)), 1'b0));
            end else if (pick < 80) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    cnt = 0;
                else if (pick < 60)
                    cnt = $urandom_range(8, 1);
                else if (pick < 80)
                    cnt = $urandom_range(64, 9);
                else if (pick < 90)
                    cnt = $urandom_range(200, 65);
                else
                    cnt = $urandom_range(8191);
                send_row(item_row(MODE_READ, BYTE_W'($urandom_range(255)), CNT_W'(cnt),
                                  1'($urandom_range(1))));
            end else if (pick < 90) begin
                send_row(item_row(MODE_WRITE, BYTE_W'($urandom_range(255)),
                                  CNT_W'($urandom_range(8191)), 1'b0));
            end else begin
                send_row(item_row(MODE_IGNORED, BYTE_W'($urandom_range(255)),
                                  CNT_W'($urandom_range(8191)), 1'($urandom_range(1))));
            end
            if ($urandom_range(99) < 2)
                drain_results();
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d data %0h granted %0d last %0d",
                       out_kind, out_data, out_granted, out_last);
                mismatch_count++;
            end else begin
                head_res = pending_results.pop_front();
                if (out_kind !== head_res.kind) begin
                    $error("kind: expected %0d, got %0d", head_res.kind, out_kind);
                    mismatch_count++;
                end
                if (out_data !== head_res.data) begin
                    $error("data_byte_out: expected %0h, got %0h", head_res.data, out_data);
                    mismatch_count++;
                end
                if (out_granted !== head_res.granted) begin
                    $error("granted_count: expected %0d, got %0d", head_res.granted,
                           out_granted);
                    mismatch_count++;
                end
                if (out_last !== head_res.last) begin
                    $error("last: expected %0d, got %0d", head_res.last, out_last);
                    mismatch_count++;
                end
            end
        end
    end

    // no transaction on any channel for too long ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[byte_pipe_ring_buffer_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        int pos;
        pos = 0;
        send_idle_pct = 7;
        recv_idle_pct = 58;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        walk_script(pos);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 7;
                recv_idle_pct = 58;
            end else if (ph < 4) begin
                send_idle_pct = 58;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_CAPACITY, CNT_W'(phase_cap[ph]));
            write_reg(CFG_ATOMIC, CNT_W'(phase_atomic[ph]));
            // unmapped indexes must be dropped
            write_reg(ph[0] ? CFG_SPARE_HI : CFG_SPARE, CNT_W'($urandom_range(8191)));
            random_phase(RANDOM_PER_PHASE);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        walk_script(pos);
        drain_results();

        if (mismatch_count == 0)
            $display("[byte_pipe_ring_buffer_top] OK");
        else
            $display("[byte_pipe_ring_buffer_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/bprb_pkg.sv
sv/bprb_store.sv
sv/bprb_ctrl.sv
sv/byte_pipe_ring_buffer_top.sv
verif/tb_byte_pipe_ring_buffer_top.sv
